>>> src/rbw_pkg.sv
// Package for the rainbow HSV to RGB generator: sizes, hue format,
// register indices, reset hue table and inter-stage types. No dependencies.
`default_nettype none

package rbw_pkg;

  localparam int NumLights = 16;
  localparam int AddrW     = (NumLights > 1) ? $clog2(NumLights) : 1;
  localparam int IndexW    = 6;
  localparam int HueW      = 15;
  localparam int FracW     = 12;
  localparam int HueSector = 1 << FracW;
  localparam int HueCircle = 6 * HueSector;
  localparam int UnitW     = 9;
  localparam int UnitMax   = 256;
  localparam int ChromaW   = 17;
  localparam int ColW      = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHueStep    = 2'd0,
    CfgSaturation = 2'd1,
    CfgBrightness = 2'd2
  } cfg_reg_e;

  typedef logic [HueW-1:0] hue_arr_t [NumLights];

  // two circles spread over the lights
  function automatic hue_arr_t init_hues();
    hue_arr_t h;
    for (int i = 0; i < NumLights; i++) begin
      h[i] = HueW'(((i * 2 * HueCircle) / NumLights) % HueCircle);
    end
    return h;
  endfunction

  localparam hue_arr_t HueInit = init_hues();

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] idx;
    logic [HueW-1:0]  hue;
  } hsv_req_t;

  typedef struct packed {
    logic [IndexW-1:0] light_index;
    logic [ColW-1:0]   red;
    logic [ColW-1:0]   green;
    logic [ColW-1:0]   blue;
    logic              last;
  } col_t;

endpackage

`default_nettype wire

>>> src/rbw_if.sv
// Handshake interfaces: frame request, colour output and register write.
// Depends on rbw_pkg.
`default_nettype none

interface rbw_req_if;
  import rbw_pkg::*;
  logic valid;
  logic ready;
  logic frame_request;
  modport source (output valid, output frame_request, input ready);
  modport sink   (input valid, input frame_request, output ready);
endinterface

interface rbw_col_if;
  import rbw_pkg::*;
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] light_index;
  logic [ColW-1:0]   red;
  logic [ColW-1:0]   green;
  logic [ColW-1:0]   blue;
  logic              last;
  modport source (output valid, output light_index, output red, output green,
                  output blue, output last, input ready);
  modport sink   (input valid, input light_index, input red, input green,
                  input blue, input last, output ready);
endinterface

interface rbw_cfg_if;
  import rbw_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/rbw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module rbw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/rbw_hsv.sv
// Two-stage HSV to RGB conversion with output register and stall control.
// Depends on rbw_pkg.
`default_nettype none

module rbw_hsv (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rbw_pkg::hsv_req_t         req_i,
  input  wire logic [rbw_pkg::ChromaW-1:0] chroma_i,
  input  wire logic [rbw_pkg::ChromaW-1:0] m_i,
  input  wire logic                      ready_i,
  output logic                           adv_o,
  output logic                           valid_o,
  output rbw_pkg::col_t                  col_o
);
  import rbw_pkg::*;

  function automatic logic [ColW-1:0] to_byte(logic [ChromaW-1:0] ch);
    logic [24:0] w;
    w = {ch, 8'b0} - {8'b0, ch} + 25'd32768;
    return w[23:16];
  endfunction

  logic             v2_q, v3_q, vo_q;
  logic [AddrW-1:0] idx2_q, idx3_q;
  logic [HueW-1:0]  hue2_q;
  logic [2:0]       sec3_q;
  logic [ChromaW-1:0] x3_q;
  col_t             col_q, col_d;

  logic [FracW:0]   t;
  logic [29:0]      prod;
  logic [2:0]       sec2;
  logic [ChromaW-1:0] rr, gg, bb;

  assign adv_o   = !vo_q || ready_i;
  assign valid_o = vo_q;
  assign col_o   = col_q;

  assign sec2 = hue2_q[HueW-1:FracW];
  assign t    = sec2[0] ? ((FracW+1)'(HueSector) - {1'b0, hue2_q[FracW-1:0]})
                        : {1'b0, hue2_q[FracW-1:0]};
  assign prod = 30'(chroma_i) * 30'(t);

  always_comb begin
    case (sec3_q)
      3'd0:    begin rr = chroma_i; gg = x3_q;     bb = '0;       end
      3'd1:    begin rr = x3_q;     gg = chroma_i; bb = '0;       end
      3'd2:    begin rr = '0;       gg = chroma_i; bb = x3_q;     end
      3'd3:    begin rr = '0;       gg = x3_q;     bb = chroma_i; end
      3'd4:    begin rr = x3_q;     gg = '0;       bb = chroma_i; end
      default: begin rr = chroma_i; gg = '0;       bb = x3_q;     end
    endcase
    col_d.light_index = IndexW'(idx3_q);
    col_d.red         = to_byte(ChromaW'(rr + m_i));
    col_d.green       = to_byte(ChromaW'(gg + m_i));
    col_d.blue        = to_byte(ChromaW'(bb + m_i));
    col_d.last        = (idx3_q == AddrW'(NumLights - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv_o) begin
      v2_q <= req_i.valid;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      idx2_q <= req_i.idx;
      hue2_q <= req_i.hue;
      idx3_q <= idx2_q;
      sec3_q <= sec2;
      x3_q   <= prod[FracW+ChromaW-1:FracW];
      col_q  <= col_d;
    end
  end

endmodule

`default_nettype wire

>>> src/rainbow_hsv_to_rgb_generator.sv
// Rainbow generator top: per-frame hue advance over a hue RAM, then HSV to RGB.
// Colours follow the request transaction at one colour a cycle while col_o is not stalled.
// A new frame is taken only after the hue RAM read-modify-write walk over all lights.
// Reset: control and config registers to reset values; hues read as the initial spread until first written.
// Depends on rbw_pkg, rbw_if, rbw_ram and rbw_hsv.
`default_nettype none

module rainbow_hsv_to_rgb_generator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rbw_cfg_if.sink    cfg_i,
  rbw_req_if.sink    req_i,
  rbw_col_if.source  col_o
);
  import rbw_pkg::*;

  logic [HueW-1:0]    step_q;
  logic [UnitW-1:0]   sat_q, bri_q;
  logic [UnitW-1:0]   s_c, v_c, v_q;
  logic [ChromaW-1:0] chroma_q, m;

  logic               run_q, run_d;
  logic [AddrW-1:0]   cnt_q, cnt_d;
  logic               v1_q, vb1_q;
  logic [AddrW-1:0]   idx1_q;
  logic [NumLights-1:0] hvld_q;

  logic               adv, start, re, we;
  logic [HueW-1:0]    rdata, hue_cur, hue_new;
  logic [HueW:0]      sum;
  hsv_req_t           hreq;
  col_t               col;
  logic               col_vld;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      sat_q  <= UnitW'(UnitMax);
      bri_q  <= UnitW'(UnitMax);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgHueStep:    step_q <= cfg_i.data[HueW-1:0];
        CfgSaturation: sat_q  <= cfg_i.data[UnitW-1:0];
        CfgBrightness: bri_q  <= cfg_i.data[UnitW-1:0];
        default:       ;
      endcase
    end
  end

  assign s_c = (sat_q > UnitW'(UnitMax)) ? UnitW'(UnitMax) : sat_q;
  assign v_c = (bri_q > UnitW'(UnitMax)) ? UnitW'(UnitMax) : bri_q;

  always_ff @(posedge clk_i) begin
    chroma_q <= ChromaW'(s_c * v_c);
    v_q      <= v_c;
  end

  assign m = {v_q, 8'b0} - chroma_q;

  // frame sequencer
  assign req_i.ready = !run_q && !v1_q;
  assign start       = req_i.valid && req_i.ready && req_i.frame_request;
  assign re          = adv && run_q;

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    if (start) begin
      run_d = 1'b1;
      cnt_d = '0;
    end else if (re) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == AddrW'(NumLights - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      v1_q   <= 1'b0;
      hvld_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      if (adv) begin
        v1_q <= run_q;
      end
      if (we) begin
        hvld_q[idx1_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      idx1_q <= cnt_q;
      vb1_q  <= hvld_q[cnt_q];
    end
  end

  // hue read-modify-write
  rbw_ram #(
    .Width (HueW),
    .Depth (NumLights)
  ) u_hue_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx1_q),
    .wdata_i (hue_new),
    .re_i    (re),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  assign hue_cur = vb1_q ? rdata : HueInit[idx1_q];
  assign sum     = {1'b0, hue_cur} + {1'b0, step_q};

  always_comb begin
    if (sum >= (HueW+1)'(2 * HueCircle)) begin
      hue_new = HueW'(sum - (HueW+1)'(2 * HueCircle));
    end else if (sum >= (HueW+1)'(HueCircle)) begin
      hue_new = HueW'(sum - (HueW+1)'(HueCircle));
    end else begin
      hue_new = sum[HueW-1:0];
    end
  end

  assign we = adv && v1_q;

  assign hreq.valid = v1_q;
  assign hreq.idx   = idx1_q;
  assign hreq.hue   = hue_new;

  rbw_hsv u_hsv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (hreq),
    .chroma_i (chroma_q),
    .m_i      (m),
    .ready_i  (col_o.ready),
    .adv_o    (adv),
    .valid_o  (col_vld),
    .col_o    (col)
  );

  assign col_o.valid       = col_vld;
  assign col_o.light_index = col.light_index;
  assign col_o.red         = col.red;
  assign col_o.green       = col.green;
  assign col_o.blue        = col.blue;
  assign col_o.last        = col.last;

endmodule

`default_nettype wire
